[rtl/hsv_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
package hsv_pkg;

	localparam int unsigned HueW  = 15;
	localparam int unsigned FracW = 13;
	localparam int unsigned ChanW = 8;

	// hue in 1/64 degree, fractions in 1/4096
	localparam logic [HueW-1:0]  HueMax  = 15'd23040;
	localparam logic [FracW-1:0] FracOne = 13'd4096;

	// one sector is 60 degrees = 3840 hue units
	localparam logic [HueW-1:0] Sector1 = 15'd3840;
	localparam logic [HueW-1:0] Sector2 = 15'd7680;
	localparam logic [HueW-1:0] Sector3 = 15'd11520;
	localparam logic [HueW-1:0] Sector4 = 15'd15360;
	localparam logic [HueW-1:0] Sector5 = 15'd19200;

	localparam int unsigned ProdW   = 25;   // v*s, at most 2^24 on valid input
	localparam int unsigned FactorW = 12;   // 0..3840
	localparam int unsigned TermW   = 36;   // products scaled by 3840
	localparam int unsigned ScaledW = 41;   // term times 17

	localparam logic [FactorW-1:0] SectorUnits = 12'd3840;
	localparam logic [ChanW-1:0]   ChanMax     = 8'd255;

	typedef logic [HueW-1:0]    hue_t;
	typedef logic [FracW-1:0]   frac_t;
	typedef logic [ChanW-1:0]   chan_t;
	typedef logic [ProdW-1:0]   prod_t;
	typedef logic [FactorW-1:0] factor_t;
	typedef logic [TermW-1:0]   term_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYA = 3'd2,
		SEC_CYA_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

[rtl/hsv_in_if.sv]
// HSV pixel channel: valid/ready handshake with hue, saturation and brightness.
interface hsv_in_if import hsv_pkg::*; ();
	logic  valid;
	logic  ready;
	hue_t  hue;
	frac_t saturation;
	frac_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

[rtl/hsv_out_if.sv]
// RGB pixel channel: valid/ready handshake with three channels and an error flag.
interface hsv_out_if import hsv_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  range_error;

	modport source (output valid, output red, output green, output blue,
		output range_error, input ready);
	modport sink (input valid, input red, input green, input blue,
		input range_error, output ready);
endinterface

[rtl/hsv_to_rgb_pixel_converter.sv]
// HSV to RGB pixel converter, four-stage pipeline.
//
// pix_in carries one HSV pixel per beat: hue in 1/64 degree (0..23040),
// saturation and brightness in 1/4096 (0..4096). pix_out carries one RGB
// beat per input beat, in order, with 8-bit red, green and blue and a
// range_error flag; an input outside its range gives range_error = 1 and
// zero channels.
// Throughput is one pixel per clock while pix_out.ready is high: every
// stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up. An accepted beat passes stages 1 to 4 in order.
// Stage 1 forms v*s, the sector and the hue ramp; stage 2 the products scaled
// by 3840; stage 3 the per-channel sums; stage 4 the times-17 scale, clamp
// and output register.
// Reset clears all valid bits; the pipeline is empty afterward.
// When the receiver holds ready low, the output beat holds and the stages
// behind it fill up; pix_in.ready drops only once every stage is occupied.
module hsv_to_rgb_pixel_converter import hsv_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	hsv_in_if.sink       pix_in,
	hsv_out_if.source    pix_out
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic    err_s1, err_s2, err_s3, err_s4;
	sector_t sector_s1, sector_s2, sector_s3;
	factor_t factor_s1;
	frac_t   v_s1;
	prod_t   p_s1;
	term_t   base_s2, pc_s2, px_s2;
	term_t   kr_s3, kg_s3, kb_s3;
	chan_t   red_s4, green_s4, blue_s4;

	assign adv_s4 = !valid_s4 || pix_out.ready;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	// Stage 1: range check, sector, ramp factor, v*s
	logic            in_err;
	sector_t         in_sector;
	logic [HueW-1:0] hue_mod;
	logic [HueW-1:0] ramp_dist;
	logic [2*FracW-1:0] in_prod;

	always_comb begin
		in_err = (pix_in.hue > HueMax) || (pix_in.saturation > FracOne)
			|| (pix_in.brightness > FracOne);
		priority if (pix_in.hue >= Sector5) begin
			in_sector = SEC_MAG_RED;
		end else if (pix_in.hue >= Sector4) begin
			in_sector = SEC_BLU_MAG;
		end else if (pix_in.hue >= Sector3) begin
			in_sector = SEC_CYA_BLU;
		end else if (pix_in.hue >= Sector2) begin
			in_sector = SEC_GRN_CYA;
		end else if (pix_in.hue >= Sector1) begin
			in_sector = SEC_YEL_GRN;
		end else begin
			in_sector = SEC_RED_YEL;
		end
		// fold hue into one 120-degree pair
		priority if (pix_in.hue >= Sector4) begin
			hue_mod = pix_in.hue - Sector4;
		end else if (pix_in.hue >= Sector2) begin
			hue_mod = pix_in.hue - Sector2;
		end else begin
			hue_mod = pix_in.hue;
		end
		ramp_dist = (hue_mod >= Sector1) ? (hue_mod - Sector1) : (Sector1 - hue_mod);
		in_prod = pix_in.brightness * pix_in.saturation;
	end

	// Stage 2 inputs: m over 3840 is 4096*v - p
	logic [ProdW-1:0] m_base;
	assign m_base = {v_s1, 12'd0} - p_s1;

	logic [TermW-1:0] base_n, pc_n;
	logic [ProdW+FactorW-1:0] px_n;
	assign base_n = TermW'(m_base * SectorUnits);
	assign pc_n   = TermW'(p_s1 * SectorUnits);
	assign px_n   = p_s1 * factor_s1;

	// Stage 3: per-channel numerators, routed by sector
	term_t kc, kx;
	term_t kr_n, kg_n, kb_n;
	always_comb begin
		kc = base_s2 + pc_s2;
		kx = base_s2 + px_s2;
		unique case (sector_s2)
			SEC_RED_YEL: begin kr_n = kc;      kg_n = kx;      kb_n = base_s2; end
			SEC_YEL_GRN: begin kr_n = kx;      kg_n = kc;      kb_n = base_s2; end
			SEC_GRN_CYA: begin kr_n = base_s2; kg_n = kc;      kb_n = kx;      end
			SEC_CYA_BLU: begin kr_n = base_s2; kg_n = kx;      kb_n = kc;      end
			SEC_BLU_MAG: begin kr_n = kx;      kg_n = base_s2; kb_n = kc;      end
			default:     begin kr_n = kc;      kg_n = base_s2; kb_n = kx;      end
		endcase
	end

	// Stage 4: channel = floor(17*k / 2^32), clamped
	function automatic chan_t scale_chan(input term_t k, input logic err);
		logic [ScaledW-1:0] t;
		t = {k, 4'd0} + ScaledW'(k);
		if (err) begin
			return '0;
		end else if (t[ScaledW-1]) begin
			return ChanMax;
		end else begin
			return t[ScaledW-2:ScaledW-1-ChanW];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= pix_in.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s1    <= in_err;
			sector_s1 <= in_sector;
			factor_s1 <= SectorUnits - FactorW'(ramp_dist);
			v_s1      <= pix_in.brightness;
			p_s1      <= in_prod[ProdW-1:0];
		end
		if (adv_s2) begin
			err_s2    <= err_s1;
			sector_s2 <= sector_s1;
			base_s2   <= base_n;
			pc_s2     <= pc_n;
			px_s2     <= px_n[TermW-1:0];
		end
		if (adv_s3) begin
			err_s3    <= err_s2;
			sector_s3 <= sector_s2;
			kr_s3     <= kr_n;
			kg_s3     <= kg_n;
			kb_s3     <= kb_n;
		end
		if (adv_s4) begin
			err_s4   <= err_s3;
			red_s4   <= scale_chan(kr_s3, err_s3);
			green_s4 <= scale_chan(kg_s3, err_s3);
			blue_s4  <= scale_chan(kb_s3, err_s3);
		end
	end

	assign pix_out.valid       = valid_s4;
	assign pix_out.red         = red_s4;
	assign pix_out.green       = green_s4;
	assign pix_out.blue        = blue_s4;
	assign pix_out.range_error = err_s4;

	// sector_s3 travels with stage 3 only so the stall check below can watch it
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.range_error |->
			pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0)
		else $error("error beat with nonzero channels");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> valid_s1)
		else $error("accepted beat not captured in stage 1");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_s4 |=> valid_s3 && $stable(kr_s3) && $stable(sector_s3))
		else $error("stalled stage 3 beat lost or changed");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 || !valid_s2 || !valid_s3 || !valid_s4 |-> pix_in.ready)
		else $error("input stalled while pipeline has room");

endmodule

[tb/tb_hsv_to_rgb_pixel_converter.sv]
// Self-checking testbench for the HSV to RGB pixel converter.
module tb_hsv_to_rgb_pixel_converter import hsv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned DrainCycles = 16;
	localparam int unsigned MaxReports = 10;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  range_error;
	} rgb_pixel_t;

	logic clk = 1'b0;
	logic arst_n;

	hsv_in_if  pix_in ();
	hsv_out_if pix_out ();

	hsv_to_rgb_pixel_converter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	rgb_pixel_t  expected_pixels[$];
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int          hold_left;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(num * 255 / den), clamped to the channel range
	function automatic chan_t scale_channel(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = (num * ChanMax) / den;
		if (q > ChanMax) begin
			q = ChanMax;
		end
		return chan_t'(q);
	endfunction

	// Exact conversion over the common denominator 4096*4096*3840.
	function automatic rgb_pixel_t convert_hsv(hue_t h, frac_t s, frac_t v);
		rgb_pixel_t      px;
		sector_t         sec;
		longint unsigned u, d, factor, den, vs, vv, c, x, m, tr, tg, tb;
		px = '0;
		if (h > HueMax || s > FracOne || v > FracOne) begin
			px.range_error = 1'b1;
			return px;
		end
		// 360 degrees falls into the last sector with x = 0
		if (h >= Sector5) begin
			sec = SEC_MAG_RED;
		end else if (h >= Sector4) begin
			sec = SEC_BLU_MAG;
		end else if (h >= Sector3) begin
			sec = SEC_CYA_BLU;
		end else if (h >= Sector2) begin
			sec = SEC_GRN_CYA;
		end else if (h >= Sector1) begin
			sec = SEC_YEL_GRN;
		end else begin
			sec = SEC_RED_YEL;
		end
		u = h % Sector2;
		d = (u >= SectorUnits) ? (u - SectorUnits) : (SectorUnits - u);
		factor = SectorUnits - d;
		vv = v;
		vs = vv * s;
		den = 64'(FracOne) * 64'(FracOne) * 64'(SectorUnits);
		c = vs * SectorUnits;
		x = vs * factor;
		m = vv * FracOne * SectorUnits - c;
		case (sec)
			SEC_RED_YEL: begin tr = c; tg = x; tb = 0; end
			SEC_YEL_GRN: begin tr = x; tg = c; tb = 0; end
			SEC_GRN_CYA: begin tr = 0; tg = c; tb = x; end
			SEC_CYA_BLU: begin tr = 0; tg = x; tb = c; end
			SEC_BLU_MAG: begin tr = x; tg = 0; tb = c; end
			default: begin tr = c; tg = 0; tb = x; end
		endcase
		px.red   = scale_channel(tr + m, den);
		px.green = scale_channel(tg + m, den);
		px.blue  = scale_channel(tb + m, den);
		return px;
	endfunction

	function automatic frac_t pick_frac();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			return '0;
		end else if (r < 20) begin
			return FracOne;
		end
		return frac_t'($urandom_range(FracOne));
	endfunction

	// Mostly in-range pixels, a share of them near sector edges; the rest raw bits.
	function automatic void pick_pixel(output hue_t h, output frac_t s, output frac_t v);
		int edge_hue;
		if ($urandom_range(99) < 12) begin
			h = hue_t'($urandom);
			s = frac_t'($urandom);
			v = frac_t'($urandom);
			return;
		end
		if ($urandom_range(4) == 0) begin
			edge_hue = int'(Sector1) * int'($urandom_range(6)) + int'($urandom_range(4)) - 2;
			if (edge_hue < 0) begin
				edge_hue = 0;
			end
			if (edge_hue > int'(HueMax)) begin
				edge_hue = int'(HueMax);
			end
			h = hue_t'(edge_hue);
		end else begin
			h = hue_t'($urandom_range(HueMax));
		end
		s = pick_frac();
		v = pick_frac();
	endfunction

	// Offer one pixel; valid stays high after the beat so back-to-back items need no gap.
	task automatic send_pixel(hue_t h, frac_t s, frac_t v);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in.valid = 1'b0;
			@(negedge clk);
		end
		pix_in.valid      = 1'b1;
		pix_in.hue        = h;
		pix_in.saturation = s;
		pix_in.brightness = v;
		do @(posedge clk); while (!pix_in.ready);
		expected_pixels.push_back(convert_hsv(h, s, v));
	endtask

	task automatic test_directed();
		send_pixel('0, FracOne, FracOne);
		send_pixel(Sector1, FracOne, FracOne);
		send_pixel(Sector2, FracOne, FracOne);
		send_pixel(Sector3, FracOne, FracOne);
		send_pixel(Sector4, FracOne, FracOne);
		send_pixel(Sector5, FracOne, FracOne);
		send_pixel(HueMax, FracOne, FracOne);
		send_pixel(15'd1920, FracOne, FracOne);
		send_pixel(Sector1 - 1, 13'd4095, 13'd4095);
		send_pixel(Sector2 - 1, FracOne, 13'd3000);
		send_pixel(Sector5 - 1, 13'd2048, FracOne);
		send_pixel(15'd22000, 13'd1234, 13'd3333);
		send_pixel(15'd11000, 13'd2048, 13'd3000);
		send_pixel(15'd5000, '0, FracOne);
		send_pixel(15'd5000, FracOne, '0);
		send_pixel(15'd12345, '0, '0);
		send_pixel(HueMax + 1, 13'd100, 13'd100);
		send_pixel('1, '0, '0);
		send_pixel(15'd100, FracOne + 1, 13'd100);
		send_pixel(15'd100, 13'd100, FracOne + 1);
		send_pixel('1, '1, '1);
		send_pixel(15'd1, 13'd1, 13'd1);
	endtask

	task automatic test_random(int unsigned count);
		hue_t  h;
		frac_t s;
		frac_t v;
		repeat (count) begin
			pick_pixel(h, s, v);
			send_pixel(h, s, v);
		end
	endtask

	// Stall the output long enough for the pipeline to fill and push back on the input.
	task automatic test_backpressure();
		hue_t  h;
		frac_t s;
		frac_t v;
		src_idle_pct = 0;
		hold_left    = 300;
		repeat (48) begin
			pick_pixel(h, s, v);
			send_pixel(h, s, v);
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			pix_out.ready = 1'b0;
			hold_left     = hold_left - 1;
		end else begin
			pix_out.ready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= MaxReports) begin
					$display("%0t: unexpected beat r=%0d g=%0d b=%0d err=%0b", $realtime,
						pix_out.red, pix_out.green, pix_out.blue, pix_out.range_error);
				end
			end else begin
				want = expected_pixels.pop_front();
				if (pix_out.red !== want.red || pix_out.green !== want.green ||
						pix_out.blue !== want.blue || pix_out.range_error !== want.range_error) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MaxReports) begin
						$display("%0t: mismatch exp r=%0d g=%0d b=%0d err=%0b, got r=%0d g=%0d b=%0d err=%0b",
							$realtime, want.red, want.green, want.blue, want.range_error,
							pix_out.red, pix_out.green, pix_out.blue, pix_out.range_error);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pix_in.valid      = 1'b0;
		pix_in.hue        = '0;
		pix_in.saturation = '0;
		pix_in.brightness = '0;
		pix_out.ready     = 1'b0;
		arst_n            = 1'b0;
		src_idle_pct      = 33;
		snk_idle_pct      = 81;
		hold_left         = 0;
		mismatch_count    = 0;
		cycle_count       = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(550);
		test_backpressure();
		src_idle_pct = 81;
		snk_idle_pct = 33;
		test_random(550);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random(550);

		@(negedge clk);
		pix_in.valid = 1'b0;
		wait (expected_pixels.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
